// File: rtl/assert_macros.svh
// assert_macros.svh
// Concurrent assertion macros for the RTL; they expand to nothing when SYNTH is defined.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/ssfg_pkg.sv
// ssfg_pkg.sv
// Constants, types and the quarter-wave sine table of the sinusoid sum frame generator.
// No dependencies.
package ssfg_pkg;

   // sizing
   localparam int NUM_WAVES        = 5;
   localparam int NUM_POINTS       = 25;
   localparam int SINE_TABLE_DEPTH = 1024;   // power of two

   localparam int NUM_CFG   = NUM_WAVES + 1;
   localparam int STEP_REG  = NUM_WAVES;
   localparam int CFG_IDX_W = $clog2(NUM_CFG);
   localparam int CFG_W     = 32;
   localparam int WAVE_W    = (NUM_WAVES > 1) ? $clog2(NUM_WAVES) : 1;
   localparam int PT_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

   // field widths
   localparam int PHASE_W     = 16;
   localparam int AMP_W       = 16;
   localparam int SINE_W      = 16;
   localparam int QTAB_DATA_W = 15;
   localparam int PROD_W      = 32;
   localparam int FRAC_SHIFT  = 15;
   localparam int CONTRIB_W   = PROD_W - FRAC_SHIFT;
   localparam int ACC_W       = CONTRIB_W + $clog2(NUM_WAVES) + 1;
   localparam int HEIGHT_W    = 19;
   localparam int POINT_IDX_W = 5;

   // sine lookup geometry
   localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
   localparam int QTR_W       = SINE_ADDR_W - 1;
   localparam int QTAB_LEN    = SINE_TABLE_DEPTH / 4 + 1;
   // angle scaling divides by twice the table depth, a power of two
   localparam int ANGLE_SHIFT = $clog2(2 * SINE_TABLE_DEPTH);

   localparam logic [PHASE_W-1:0] QUARTER_TURN     = PHASE_W'(16384);
   localparam logic [PHASE_W-1:0] FRAME_STEP_RESET = PHASE_W'(209);
   localparam logic [PROD_W-1:0]  ROUND_HALF       = PROD_W'(1 << (FRAC_SHIFT - 1));

   localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (HEIGHT_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (HEIGHT_W - 1)));

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   typedef logic [QTAB_DATA_W-1:0] qtab_type [0:QTAB_LEN-1];

   // tag that travels with each wave step through the MAC pipe
   typedef struct packed {
      logic            valid;
      logic            last;   // final wave of the point
      logic [PT_W-1:0] pt;
   } wave_tag_type;

   // finished point leaving the MAC unit
   typedef struct packed {
      logic                       valid;
      logic [PT_W-1:0]            pt;
      logic signed [HEIGHT_W-1:0] sum;
   } point_result_type;

   // two Q30 multiplies of the Taylor term by x
   function automatic logic [63:0] taylor_raise(input logic [63:0] term, input logic [63:0] x);
      logic [63:0] t;
      t = (term * x) >> 30;
      t = (t * x) >> 30;
      return t;
   endfunction

   // sine of q/(table depth) turns for 0 <= q <= depth/4, Q1.15 magnitude
   function automatic logic [QTAB_DATA_W-1:0] quarter_sine(input int unsigned q);
      logic [63:0]        x;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      x    = (64'(4 * q) * PI_Q30) >> ANGLE_SHIFT;
      term = x;
      sum  = $signed(x);
      term = taylor_raise(term, x) / 64'd6;
      sum  = sum - $signed(term);
      term = taylor_raise(term, x) / 64'd20;
      sum  = sum + $signed(term);
      term = taylor_raise(term, x) / 64'd42;
      sum  = sum - $signed(term);
      term = taylor_raise(term, x) / 64'd72;
      sum  = sum + $signed(term);
      term = taylor_raise(term, x) / 64'd110;
      sum  = sum - $signed(term);
      term = taylor_raise(term, x) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[QTAB_DATA_W-1:0];
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int unsigned i = 0; i < QTAB_LEN; i++) begin
         t[i] = quarter_sine(i);
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

endpackage

// File: rtl/ssfg_wave_mac.sv
// ssfg_wave_mac.sv
// Shared wave unit: sine lookup, amplitude multiply, rounding and per-point accumulation.
// Depends on ssfg_pkg.
module ssfg_wave_mac
   import ssfg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  wave_tag_type            issue_tag,
   input  logic [PHASE_W-1:0]      issue_phase,
   input  logic signed [AMP_W-1:0] issue_amp,
   output point_result_type        result
);

   localparam logic [QTR_W-1:0]       QTR_POINT  = QTR_W'(SINE_TABLE_DEPTH / 4);
   localparam logic [SINE_ADDR_W-1:0] HALF_POINT = SINE_ADDR_W'(SINE_TABLE_DEPTH / 2);

   // stage 1: table address folded into the first quarter
   wave_tag_type             s1_tag_ff;
   logic [QTR_W-1:0]         s1_q_ff, s1_q_in;
   logic                     s1_neg_ff, s1_neg_in;
   logic signed [AMP_W-1:0]  s1_amp_ff;
   // stage 2: signed sine value
   wave_tag_type             s2_tag_ff;
   logic signed [SINE_W-1:0] s2_sine_ff, s2_sine_in;
   logic signed [AMP_W-1:0]  s2_amp_ff;
   // stage 3: product
   wave_tag_type             s3_tag_ff;
   logic signed [PROD_W-1:0] s3_prod_ff, s3_prod_in;
   // stage 4: accumulate
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   point_result_type         result_ff, result_in;

   logic [SINE_ADDR_W-1:0]   addr;
   logic [QTR_W-1:0]         half_idx;
   logic [QTAB_DATA_W-1:0]   qval;
   logic [PROD_W-1:0]        rounded;
   logic signed [CONTRIB_W-1:0] contrib;
   logic signed [ACC_W-1:0]  acc_sum;

   // fold phase into quarter-wave index and sign
   always_comb begin
      addr      = issue_phase[PHASE_W-1 -: SINE_ADDR_W];
      half_idx  = addr[QTR_W-1:0];
      s1_neg_in = addr[SINE_ADDR_W-1];
      if (half_idx > QTR_POINT) begin
         s1_q_in = QTR_W'(HALF_POINT - {1'b0, half_idx});
      end else begin
         s1_q_in = half_idx;
      end
   end

   // table read and sign
   always_comb begin
      qval = QTAB[s1_q_ff];
      if (s1_neg_ff) begin
         s2_sine_in = -$signed({1'b0, qval});
      end else begin
         s2_sine_in = $signed({1'b0, qval});
      end
   end

   assign s3_prod_in = PROD_W'(s2_amp_ff) * PROD_W'(s2_sine_ff);

   // round half up, accumulate, saturate on the last wave
   always_comb begin
      rounded   = $unsigned(s3_prod_ff) + ROUND_HALF;
      contrib   = $signed(rounded[PROD_W-1:FRAC_SHIFT]);
      acc_sum   = acc_ff + ACC_W'(contrib);
      acc_in    = acc_ff;
      result_in = '0;
      result_in.pt = s3_tag_ff.pt;
      if (acc_sum > SAT_HI) begin
         result_in.sum = HEIGHT_W'(SAT_HI);
      end else if (acc_sum < SAT_LO) begin
         result_in.sum = HEIGHT_W'(SAT_LO);
      end else begin
         result_in.sum = HEIGHT_W'(acc_sum);
      end
      if (s3_tag_ff.valid) begin
         if (s3_tag_ff.last) begin
            acc_in          = '0;
            result_in.valid = 1'b1;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         acc_ff    <= '0;
         result_ff <= '0;
      end else begin
         s1_tag_ff <= issue_tag;
         s2_tag_ff <= s1_tag_ff;
         s3_tag_ff <= s2_tag_ff;
         acc_ff    <= acc_in;
         result_ff <= result_in;
      end
      s1_q_ff    <= s1_q_in;
      s1_neg_ff  <= s1_neg_in;
      s1_amp_ff  <= issue_amp;
      s2_sine_ff <= s2_sine_in;
      s2_amp_ff  <= s1_amp_ff;
      s3_prod_ff <= s3_prod_in;
   end

   assign result = result_ff;

endmodule

// File: rtl/sinusoid_sum_frame_generator.sv
// sinusoid_sum_frame_generator.sv
// Top level: config registers, point/wave sequencer, output buffering.
// Depends on ssfg_pkg, ssfg_wave_mac and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_frame_request
//   rsp_     out        rsp_valid/rsp_ready  rsp_point_index, rsp_height, rsp_last_point
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A frame item issues one wave step per cycle, unless issue is paused, into the shared
// lookup/multiply/accumulate unit, five steps per point. Only two points may be outstanding.
// Reset is synchronous; it restores config defaults and clears phase and control state.
// Issue pauses whenever two points are started and not yet delivered; rsp_ready low extends it.
`include "assert_macros.svh"
module sinusoid_sum_frame_generator
   import ssfg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // frame requests
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_frame_request,
   // points
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [POINT_IDX_W-1:0]     rsp_point_index,
   output logic signed [HEIGHT_W-1:0] rsp_height,
   output logic                       rsp_last_point,
   // config writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_IDX_W-1:0]       csr_index,
   input  logic [CFG_W-1:0]           csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // config registers
   logic [CFG_W-1:0]   wave_cfg_ff [NUM_WAVES];
   logic [PHASE_W-1:0] step_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic [PHASE_W-1:0] frame_phase_ff, frame_phase_in;
   logic [PHASE_W-1:0] wave_phase_ff [NUM_WAVES];
   logic [PHASE_W-1:0] wave_phase_in [NUM_WAVES];
   logic [WAVE_W-1:0]  wave_ff, wave_in;
   logic [PT_W-1:0]    pt_ff, pt_in;
   logic [1:0]         pend_ff, pend_in;    // points started and not yet delivered

   // point holding register and output register
   logic                       ps_valid_ff, ps_valid_in;
   logic [PT_W-1:0]            ps_pt_ff, ps_pt_in;
   logic signed [HEIGHT_W-1:0] ps_sum_ff, ps_sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [POINT_IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic signed [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                    csr_we;
   logic                    issue_go;
   logic                    start_pt;
   logic                    last_wave;
   logic                    last_pt;
   logic                    rsp_take;
   logic                    ps_move;
   logic [PHASE_W-1:0]      new_frame_phase;
   logic [PHASE_W-1:0]      cur_phase;
   logic [CFG_W-1:0]        cur_cfg;
   wave_tag_type            issue_tag;
   logic [PHASE_W-1:0]      issue_phase;
   logic signed [AMP_W-1:0] issue_amp;
   point_result_type        mac_result;

   // config write port, always ready
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_WAVES; j++) begin
            wave_cfg_ff[j] <= '0;
         end
         step_ff <= FRAME_STEP_RESET;
      end else if (csr_we) begin
         for (int j = 0; j < NUM_WAVES; j++) begin
            if (csr_index == CFG_IDX_W'(j)) begin
               wave_cfg_ff[j] <= csr_wdata;
            end
         end
         if (csr_index == CFG_IDX_W'(STEP_REG)) begin
            step_ff <= csr_wdata[PHASE_W-1:0];
         end
      end
   end

   // issue control
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign ps_move   = ps_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign last_wave = (wave_ff == WAVE_W'(NUM_WAVES - 1));
   assign last_pt   = (pt_ff == PT_W'(NUM_POINTS - 1));
   assign issue_go  = (state_ff == ST_RUN) && ((wave_ff != '0) || (pend_ff < 2'd2));
   assign start_pt  = issue_go && (wave_ff == '0);
   assign cur_phase = wave_phase_ff[wave_ff];
   assign cur_cfg   = wave_cfg_ff[wave_ff];
   assign new_frame_phase = frame_phase_ff + step_ff;

   // odd waves are cosines: a quarter turn ahead
   always_comb begin
      issue_tag.valid = issue_go;
      issue_tag.last  = last_wave;
      issue_tag.pt    = pt_ff;
      issue_phase     = wave_ff[0] ? (cur_phase + QUARTER_TURN) : cur_phase;
      issue_amp       = $signed(cur_cfg[CFG_W-1 -: AMP_W]);
   end

   ssfg_wave_mac u_wave_mac (
      .clock       (clock),
      .reset       (reset),
      .issue_tag   (issue_tag),
      .issue_phase (issue_phase),
      .issue_amp   (issue_amp),
      .result      (mac_result)
   );

   // sequencer next state
   always_comb begin
      state_in       = state_ff;
      frame_phase_in = frame_phase_ff;
      wave_phase_in  = wave_phase_ff;
      wave_in        = wave_ff;
      pt_in          = pt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_frame_request) begin
               frame_phase_in = new_frame_phase;
               for (int j = 0; j < NUM_WAVES; j++) begin
                  wave_phase_in[j] = new_frame_phase;
               end
               wave_in  = '0;
               pt_in    = '0;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue_go) begin
               for (int j = 0; j < NUM_WAVES; j++) begin
                  if (wave_ff == WAVE_W'(j)) begin
                     wave_phase_in[j] = cur_phase + cur_cfg[PHASE_W-1:0];
                  end
               end
               if (last_wave) begin
                  wave_in = '0;
                  if (last_pt) begin
                     state_in = ST_DRAIN;
                  end else begin
                     pt_in = pt_ff + PT_W'(1);
                  end
               end else begin
                  wave_in = wave_ff + WAVE_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            if (pend_ff == 2'd0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outstanding point count
   always_comb begin
      pend_in = pend_ff;
      if (start_pt && !rsp_take) begin
         pend_in = pend_ff + 2'd1;
      end else if (!start_pt && rsp_take) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   // point buffer and output register
   always_comb begin
      ps_valid_in   = ps_valid_ff;
      ps_pt_in      = ps_pt_ff;
      ps_sum_in     = ps_sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_height_in = rsp_height_ff;
      rsp_last_in   = rsp_last_ff;
      if (ps_move) begin
         rsp_valid_in  = 1'b1;
         rsp_idx_in    = POINT_IDX_W'(ps_pt_ff);
         rsp_height_in = ps_sum_ff;
         rsp_last_in   = (ps_pt_ff == PT_W'(NUM_POINTS - 1));
         ps_valid_in   = 1'b0;
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
      if (mac_result.valid) begin
         ps_valid_in = 1'b1;
         ps_pt_in    = mac_result.pt;
         ps_sum_in   = mac_result.sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_phase_ff <= '0;
         for (int j = 0; j < NUM_WAVES; j++) begin
            wave_phase_ff[j] <= '0;
         end
         wave_ff        <= '0;
         pt_ff          <= '0;
         pend_ff        <= '0;
         ps_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_phase_ff <= frame_phase_in;
         wave_phase_ff  <= wave_phase_in;
         wave_ff        <= wave_in;
         pt_ff          <= pt_in;
         pend_ff        <= pend_in;
         ps_valid_ff    <= ps_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      ps_pt_ff      <= ps_pt_in;
      ps_sum_ff     <= ps_sum_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_height_ff <= rsp_height_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_point_index = rsp_idx_ff;
   assign rsp_height      = rsp_height_ff;
   assign rsp_last_point  = rsp_last_ff;

   // a finished point never lands on one that cannot move on
   `ASSERT_IMPLY(a_no_point_overwrite, clock, reset, mac_result.valid && ps_valid_ff, ps_move)
   // idle only once every point of the frame has been delivered
   `ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, !rsp_valid_ff && !ps_valid_ff)
   // a frame request starts issuing on the next cycle
   `ASSERT_NEXT(a_request_starts, clock, reset, req_valid && req_ready && req_frame_request, state_ff == ST_RUN)

endmodule
